// ===== hw/rtl/serial_loaded_bank_mapper_macros.svh =====
// Assertion helpers for the bank mapper. Each expects clk and rst_n in scope.
`ifndef SERIAL_LOADED_BANK_MAPPER_MACROS_SVH
`define SERIAL_LOADED_BANK_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
`define SLBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slbm: same-cycle check failed");
`define SLBM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slbm: next-cycle check failed");
`else
`define SLBM_ASSERT_IMP(lbl, ante, cons)
`define SLBM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/slbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slbm_pkg;

    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int TGT_W   = 2;
    localparam int MAP_W   = 18;
    localparam int MIRR_W  = 2;
    localparam int COUNT_W = 5;

    // bus request kinds
    localparam logic [FUNC_W-1:0] FUNC_CPU_RD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CPU_WR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PPU    = 2'd2;

    // target memories
    localparam logic [TGT_W-1:0] TGT_NONE    = 2'd0;
    localparam logic [TGT_W-1:0] TGT_PRG_ROM = 2'd1;
    localparam logic [TGT_W-1:0] TGT_PRG_RAM = 2'd2;
    localparam logic [TGT_W-1:0] TGT_CHR     = 2'd3;

    // serial register select, address bits 14:13
    localparam logic [1:0] SEL_CTRL   = 2'd0;
    localparam logic [1:0] SEL_CHR_LO = 2'd1;
    localparam logic [1:0] SEL_CHR_HI = 2'd2;
    localparam logic [1:0] SEL_PRG    = 2'd3;

    // ROM layouts: 0/1 switch 32KB, 2 fixes first bank low, 3 fixes last bank high
    localparam logic [1:0] LAYOUT_FIX_FIRST = 2'd2;
    localparam logic [1:0] LAYOUT_FIX_LAST  = 2'd3;

    localparam logic [4:0]         SHIFT_EMPTY     = 5'h10;
    localparam logic [COUNT_W-1:0] BANK_COUNT_RST  = 5'd16;
    localparam logic [2:0]         RAM_WINDOW_TOP  = 3'b011;   // 0x6000-0x7FFF

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } slbm_item_t;

    typedef struct packed {
        logic [4:0] load_shift;
        logic [1:0] mirror_mode;
        logic [1:0] rom_layout;
        logic       chr_4k_mode;
        logic [4:0] chr_bank_low;
        logic [4:0] chr_bank_high;
        logic [3:0] prg_bank;
        logic       ram_off;
    } slbm_state_t;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [MAP_W-1:0] mapped;
    } slbm_xlate_t;

    localparam slbm_state_t STATE_RST = '{
        load_shift:    SHIFT_EMPTY,
        mirror_mode:   2'd0,
        rom_layout:    LAYOUT_FIX_LAST,
        chr_4k_mode:   1'b0,
        chr_bank_low:  5'd0,
        chr_bank_high: 5'd0,
        prg_bank:      4'd0,
        ram_off:       1'b0
    };

endpackage

`default_nettype wire

// ===== hw/rtl/slbm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface slbm_access_if;
    import slbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    modport source (output valid, func, address, write_data, input ready);
    modport sink   (input valid, func, address, write_data, output ready);
endinterface

interface slbm_result_if;
    import slbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [TGT_W-1:0]  target;
    logic [MAP_W-1:0]  mapped_address;
    logic [MIRR_W-1:0] mirroring;
    logic              ram_disabled;
    modport source (output valid, target, mapped_address, mirroring, ram_disabled,
                    input ready);
    modport sink   (input valid, target, mapped_address, mirroring, ram_disabled,
                    output ready);
endinterface

interface slbm_cfg_if;
    import slbm_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] prg_bank_count;
    modport source (output valid, prg_bank_count, input ready);
    modport sink   (input valid, prg_bank_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slbm_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "serial_loaded_bank_mapper_macros.svh"

// Serial load register and the four mapper registers.
module slbm_regs (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   take,
    input  wire slbm_pkg::slbm_item_t item,
    output slbm_pkg::slbm_state_t cur,
    output slbm_pkg::slbm_state_t nxt
);
    import slbm_pkg::*;

    slbm_state_t state_reg;
    slbm_state_t state_next;
    logic [4:0]  shifted;
    logic        reg_write;

    assign shifted   = {item.write_data[0], state_reg.load_shift[4:1]};
    assign reg_write = take && (item.func == FUNC_CPU_WR) && item.address[15];

    always_comb
    begin
        state_next = state_reg;
        if (reg_write)
        begin
            if (item.write_data[7])
            begin
                state_next.load_shift = SHIFT_EMPTY;
            end
            else if (!state_reg.load_shift[0])
            begin
                state_next.load_shift = shifted;
            end
            else
            begin
                state_next.load_shift = SHIFT_EMPTY;
                case (item.address[14:13])
                    SEL_CTRL:
                    begin
                        state_next.mirror_mode = shifted[1:0];
                        state_next.rom_layout  = shifted[3:2];
                        state_next.chr_4k_mode = shifted[4];
                    end
                    SEL_CHR_LO:
                    begin
                        // 8KB mode drops the low bank bit
                        state_next.chr_bank_low = {shifted[4:1],
                                                   shifted[0] & state_reg.chr_4k_mode};
                    end
                    SEL_CHR_HI:
                    begin
                        if (state_reg.chr_4k_mode)
                        begin
                            state_next.chr_bank_high = shifted;
                        end
                    end
                    default:
                    begin
                        // 32KB mode drops the low bank bit
                        state_next.prg_bank = {shifted[3:1],
                                               shifted[0] & state_reg.rom_layout[1]};
                        state_next.ram_off  = shifted[4];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cur = state_reg;
    assign nxt = state_next;

    // the marker bit never leaves the load register
    `SLBM_ASSERT_IMP(a_shift_marker, 1'b1, state_reg.load_shift != 5'd0)
    `SLBM_ASSERT_NXT(a_clear_bit, reg_write && item.write_data[7],
                     state_reg.load_shift == SHIFT_EMPTY)
    `SLBM_ASSERT_NXT(a_no_update, take && (item.func != FUNC_CPU_WR), $stable(state_reg))

endmodule

`default_nettype wire

// ===== hw/rtl/slbm_xlate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Address translation for one request against the current mapper state.
module slbm_xlate (
    input  wire slbm_pkg::slbm_item_t        item,
    input  wire slbm_pkg::slbm_state_t       state,
    input  wire [slbm_pkg::COUNT_W-1:0]      prg_bank_count,
    output slbm_pkg::slbm_xlate_t            xlate
);
    import slbm_pkg::*;

    logic [COUNT_W-1:0] last_count;
    logic [3:0]         last_bank;
    logic [3:0]         bank16;
    logic [MAP_W-1:0]   prg_map;
    logic [MAP_W-1:0]   chr_map;
    logic [12:0]        pa;
    logic               in_ram;

    assign last_count = prg_bank_count - COUNT_W'(1);
    assign last_bank  = last_count[3:0];
    assign pa         = item.address[12:0];
    assign in_ram     = (item.address[15:13] == RAM_WINDOW_TOP);

    always_comb
    begin
        bank16 = state.prg_bank;
        if (!item.address[14])
        begin
            if (state.rom_layout == LAYOUT_FIX_FIRST)
            begin
                bank16 = 4'd0;
            end
        end
        else if (state.rom_layout == LAYOUT_FIX_LAST)
        begin
            bank16 = last_bank;
        end

        if (!state.rom_layout[1])
        begin
            prg_map = {state.prg_bank[3:1], item.address[14:0]};
        end
        else
        begin
            prg_map = {bank16, item.address[13:0]};
        end
    end

    always_comb
    begin
        if (!pa[12] || !state.chr_4k_mode)
        begin
            chr_map = {1'b0, state.chr_bank_low, 12'd0} + {5'd0, pa};
        end
        else
        begin
            chr_map = {1'b0, state.chr_bank_high, pa[11:0]};
        end
    end

    always_comb
    begin
        xlate.target = TGT_NONE;
        xlate.mapped = '0;
        case (item.func)
            FUNC_CPU_RD:
            begin
                if (in_ram)
                begin
                    xlate.target = TGT_PRG_RAM;
                    xlate.mapped = {5'd0, pa};
                end
                else if (item.address[15])
                begin
                    xlate.target = TGT_PRG_ROM;
                    xlate.mapped = prg_map;
                end
            end
            FUNC_CPU_WR:
            begin
                if (in_ram)
                begin
                    xlate.target = TGT_PRG_RAM;
                    xlate.mapped = {5'd0, pa};
                end
            end
            FUNC_PPU:
            begin
                xlate.target = TGT_CHR;
                xlate.mapped = chr_map;
            end
            default:
            begin
                xlate.target = TGT_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/serial_loaded_bank_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "serial_loaded_bank_mapper_macros.svh"

// Cartridge bank mapper (MMC1 style). Every bus request on the access channel
// (CPU read, CPU write or PPU pattern access) gives exactly one result: the
// memory reached (none, PRG ROM, PRG RAM or CHR), the byte offset within it,
// and the mirroring mode and PRG RAM disable bit as they stand after the
// request. CPU writes at 0x8000 and up shift one bit at a time into a five-bit
// load register; bit 7 set clears it, and the fifth bit commits the value to
// the register picked by address bits 14:13. PRG RAM sits at 0x6000-0x7FFF.
// Throughput is one request per clock while the result side is not stalled.
// The accepting edge loads the input register, and the result register loads
// from it once it has room; these are the two register stages around the
// single translate/update pass. Result stalls hold both stages; the access
// channel keeps taking requests while either stage has room. The PRG bank
// count is written on the cfg channel (always ready); the user must write it
// only while no request is in flight, as the block itself does not enforce it.
module serial_loaded_bank_mapper (
    input  wire            clk,
    input  wire            rst_n,
    slbm_access_if.sink    access,
    slbm_result_if.source  result,
    slbm_cfg_if.sink       cfg
);
    import slbm_pkg::*;

    // configuration
    logic [COUNT_W-1:0] prg_bank_count_reg;

    // input stage
    logic        s1_valid_reg;
    slbm_item_t  s1_item_reg;
    logic        s1_advance;
    logic        out_load;

    // result stage
    logic              out_valid_reg;
    logic [TGT_W-1:0]  out_target_reg;
    logic [MAP_W-1:0]  out_mapped_reg;
    logic [MIRR_W-1:0] out_mirror_reg;
    logic              out_ram_off_reg;

    slbm_state_t cur_state;
    slbm_state_t nxt_state;
    slbm_xlate_t xlate;
    slbm_item_t  access_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg <= BANK_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            prg_bank_count_reg <= cfg.prg_bank_count;
        end
    end

    // handshake: result register frees up when empty or being drained
    assign out_load     = !out_valid_reg || result.ready;
    assign s1_advance   = s1_valid_reg && out_load;
    assign access.ready = !s1_valid_reg || s1_advance;

    assign access_item.func       = access.func;
    assign access_item.address    = access.address;
    assign access_item.write_data = access.write_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (access.ready)
        begin
            s1_valid_reg <= access.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (access.valid && access.ready)
        begin
            s1_item_reg <= access_item;
        end
    end

    // state only moves when the request leaves the input stage
    slbm_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (s1_advance),
        .item  (s1_item_reg),
        .cur   (cur_state),
        .nxt   (nxt_state)
    );

    slbm_xlate u_xlate (
        .item           (s1_item_reg),
        .state          (cur_state),
        .prg_bank_count (prg_bank_count_reg),
        .xlate          (xlate)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // mirroring and RAM-off are reported after this request's update
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_target_reg  <= xlate.target;
            out_mapped_reg  <= xlate.mapped;
            out_mirror_reg  <= nxt_state.mirror_mode;
            out_ram_off_reg <= nxt_state.ram_off;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.target         = out_target_reg;
    assign result.mapped_address = out_mapped_reg;
    assign result.mirroring      = out_mirror_reg;
    assign result.ram_disabled   = out_ram_off_reg;

    `SLBM_ASSERT_NXT(a_advance_fills, s1_advance, out_valid_reg)
    `SLBM_ASSERT_IMP(a_stall_cause, !access.ready,
                     s1_valid_reg && out_valid_reg && !result.ready)
    `SLBM_ASSERT_NXT(a_ppu_to_chr, s1_advance && (s1_item_reg.func == FUNC_PPU),
                     out_target_reg == TGT_CHR)
    `SLBM_ASSERT_NXT(a_low_write_none,
                     s1_advance && (s1_item_reg.func == FUNC_CPU_WR)
                     && s1_item_reg.address[15],
                     out_target_reg == TGT_NONE)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import slbm_pkg::*;

    // Request kind the block must treat as a no-op
    localparam logic [FUNC_W-1:0] FUNC_INVALID = 2'd3;

    // CPU address map
    localparam logic [ADDR_W-1:0] RAM_BASE  = 16'h6000;
    localparam logic [ADDR_W-1:0] RAM_LAST  = 16'h7FFF;
    localparam logic [ADDR_W-1:0] ROM_BASE  = 16'h8000;
    localparam logic [ADDR_W-1:0] ROM_UPPER = 16'hC000;

    // bit 7 of a ROM-space write empties the serial load register
    localparam int CLEAR_BIT = 7;

    localparam int PHASE_REQUESTS = 155;
    localparam int SETTLE_CYCLES  = 4;      // two register stages, plus margin
    localparam int TAIL_CYCLES    = 10;
    localparam int MAX_CYCLES     = 500000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [TGT_W-1:0]  target;
        logic [MAP_W-1:0]  mapped;
        logic [MIRR_W-1:0] mirroring;
        logic              ram_disabled;
    } bank_map_t;

    // Scoreboard: carries its own copy of the mapper registers, works out the
    // translation for every accepted request and checks results in order.
    class bank_map_scoreboard;
        slbm_state_t        regs;
        logic [COUNT_W-1:0] bank_total;
        bank_map_t          expected_maps[$];
        int unsigned        failures;
        int unsigned        reported;

        function new();
            regs       = STATE_RST;
            bank_total = BANK_COUNT_RST;
            failures   = 0;
            reported   = 0;
        endfunction

        function void set_bank_count(logic [COUNT_W-1:0] count);
            bank_total = count;
        endfunction

        function int outstanding();
            return expected_maps.size();
        endfunction

        function void commit(logic [1:0] sel, logic [4:0] value);
            case (sel)
                SEL_CTRL:
                begin
                    regs.mirror_mode = value[1:0];
                    regs.rom_layout  = value[3:2];
                    regs.chr_4k_mode = value[4];
                end
                SEL_CHR_LO:
                begin
                    regs.chr_bank_low = value;
                    // 8KB mode: low bank is always even
                    if (!regs.chr_4k_mode)
                        regs.chr_bank_low[0] = 1'b0;
                end
                SEL_CHR_HI:
                begin
                    // ignored altogether in 8KB mode
                    if (regs.chr_4k_mode)
                        regs.chr_bank_high = value;
                end
                default:
                begin
                    regs.prg_bank = value[3:0];
                    // 32KB mode: stored bank is forced even
                    if (regs.rom_layout < LAYOUT_FIX_FIRST)
                        regs.prg_bank[0] = 1'b0;
                    regs.ram_off = value[4];
                end
            endcase
        endfunction

        function logic [MAP_W-1:0] rom_offset(logic [ADDR_W-1:0] addr);
            logic [3:0]         page;
            logic [14:0]        offset;
            logic [COUNT_W-1:0] last_page;
            // count of 0 wraps to bank 15, counts above 16 taken modulo 16
            last_page = bank_total - COUNT_W'(1);
            if (regs.rom_layout < LAYOUT_FIX_FIRST)
            begin
                page   = {regs.prg_bank[3:1], 1'b0};
                offset = addr[14:0];
            end
            else if (addr < ROM_UPPER)
            begin
                page   = (regs.rom_layout == LAYOUT_FIX_FIRST) ? 4'd0 : regs.prg_bank;
                offset = {1'b0, addr[13:0]};
            end
            else
            begin
                page   = (regs.rom_layout == LAYOUT_FIX_LAST) ? last_page[3:0]
                                                              : regs.prg_bank;
                offset = {1'b0, addr[13:0]};
            end
            return {page, 14'h0000} + {3'b000, offset};
        endfunction

        // Translate one request and apply any register update it carries
        function bank_map_t map_access(slbm_item_t req);
            bank_map_t  res;
            logic       was_full;
            logic [12:0] pa;
            res = '0;
            case (req.func)
                FUNC_CPU_RD:
                begin
                    if (req.address >= RAM_BASE && req.address <= RAM_LAST)
                    begin
                        res.target = TGT_PRG_RAM;
                        res.mapped = MAP_W'(req.address - RAM_BASE);
                    end
                    else if (req.address >= ROM_BASE)
                    begin
                        res.target = TGT_PRG_ROM;
                        res.mapped = rom_offset(req.address);
                    end
                end
                FUNC_CPU_WR:
                begin
                    if (req.address >= RAM_BASE && req.address <= RAM_LAST)
                    begin
                        res.target = TGT_PRG_RAM;
                        res.mapped = MAP_W'(req.address - RAM_BASE);
                    end
                    else if (req.address >= ROM_BASE)
                    begin
                        if (req.write_data[CLEAR_BIT])
                            regs.load_shift = SHIFT_EMPTY;
                        else
                        begin
                            was_full        = regs.load_shift[0];
                            regs.load_shift = {req.write_data[0], regs.load_shift[4:1]};
                            if (was_full)
                            begin
                                commit(req.address[14:13], regs.load_shift);
                                regs.load_shift = SHIFT_EMPTY;
                            end
                        end
                    end
                end
                FUNC_PPU:
                begin
                    pa         = req.address[12:0];
                    res.target = TGT_CHR;
                    if (!pa[12] || !regs.chr_4k_mode)
                        res.mapped = {1'b0, regs.chr_bank_low, 12'h000} + {5'b0, pa};
                    else
                        res.mapped = {1'b0, regs.chr_bank_high, 12'h000} + {6'b0, pa[11:0]};
                end
                default:
                    ;
            endcase
            res.mirroring    = regs.mirror_mode;
            res.ram_disabled = regs.ram_off;
            return res;
        endfunction

        function void note_request(slbm_item_t req);
            expected_maps.push_back(map_access(req));
        endfunction

        function void check_result(bank_map_t got);
            bank_map_t want;
            if (expected_maps.size() == 0)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("unexpected result: target %0d addr %05h mirr %0d ram_dis %0b",
                             got.target, got.mapped, got.mirroring, got.ram_disabled);
                end
                return;
            end
            want = expected_maps.pop_front();
            if (got !== want)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("mismatch: exp target %0d addr %05h mirr %0d ram_dis %0b",
                             want.target, want.mapped, want.mirroring, want.ram_disabled);
                    $display("          got target %0d addr %05h mirr %0d ram_dis %0b",
                             got.target, got.mapped, got.mirroring, got.ram_disabled);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    slbm_access_if acc_if ();
    slbm_result_if res_if ();
    slbm_cfg_if    cfg_ch ();

    serial_loaded_bank_mapper dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (acc_if),
        .result (res_if),
        .cfg    (cfg_ch)
    );

    bank_map_scoreboard sb;
    int unsigned        cycle_count;
    int unsigned        phase_count;
    bit                 tx_calm;        // sender never idles while set
    bit                 rx_calm;        // receiver never stalls while set

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic slbm_item_t random_access();
        slbm_item_t  req;
        logic [31:0] rnd;
        int          r;
        rnd            = $urandom;
        req.address    = rnd[15:0];
        req.write_data = rnd[23:16];
        r = $urandom_range(0, 99);
        if (r < 35)
            req.func = FUNC_CPU_RD;
        else if (r < 45)
            req.func = FUNC_CPU_WR;
        else if (r < 95)
            req.func = FUNC_PPU;
        else
            req.func = FUNC_INVALID;
        r   = $urandom_range(0, 3);
        rnd = $urandom;
        if (req.func == FUNC_PPU)
        begin
            // mostly legal pattern addresses, a few with high bits set
            if (r != 0)
                req.address = {3'b000, rnd[12:0]};
        end
        else if (r == 1)
            req.address = RAM_BASE | {3'b000, rnd[12:0]};
        else if (r >= 2)
            req.address = {1'b1, rnd[14:0]};
        return req;
    endfunction

    // Present one request and hold it until accepted, then maybe idle
    task automatic issue(input slbm_item_t req);
        int gap;
        acc_if.valid      <= 1'b1;
        acc_if.func       <= req.func;
        acc_if.address    <= req.address;
        acc_if.write_data <= req.write_data;
        do
            @(posedge clk);
        while (acc_if.ready !== 1'b1);
        sb.note_request(req);
        phase_count++;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            acc_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Five serial writes loading one register; the last write's address picks
    // the register. With noise on, stray requests and the odd clearing write
    // land inside the sequence.
    task automatic serial_load(input logic [1:0] sel, input logic [4:0] value,
                               input bit noisy);
        slbm_item_t  req;
        logic [31:0] rnd;
        for (int i = 0; i < 5; i++)
        begin
            if (noisy && $urandom_range(0, 5) == 0)
                issue(random_access());
            if (noisy && $urandom_range(0, 24) == 0)
            begin
                rnd = $urandom;
                req = '{FUNC_CPU_WR, {1'b1, rnd[14:0]}, {1'b1, rnd[22:16]}};
                issue(req);
            end
            rnd            = $urandom;
            req.func       = FUNC_CPU_WR;
            req.address    = (i == 4) ? {1'b1, sel, rnd[12:0]} : {1'b1, rnd[14:0]};
            req.write_data = {1'b0, rnd[21:16], value[i]};
            issue(req);
        end
    endtask

    // Let every expected result come back, then let the pipeline settle
    task automatic drain_results();
        acc_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bank_count(input logic [COUNT_W-1:0] count);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.prg_bank_count <= count;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.set_bank_count(count);
    endtask

    // Result side: ready in runs, broken by random stalls
    initial
    begin
        int stall;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            stall = rx_calm ? 0 : pick_gap();
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Result monitor and watchdog
    always @(posedge clk)
    begin
        bank_map_t got;
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            got.target       = res_if.target;
            got.mapped       = res_if.mapped_address;
            got.mirroring    = res_if.mirroring;
            got.ram_disabled = res_if.ram_disabled;
            sb.check_result(got);
        end
    end

    initial
    begin
        logic [COUNT_W-1:0] counts [8];
        sb          = new();
        cycle_count = 0;
        phase_count = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;

        acc_if.valid          <= 1'b0;
        acc_if.func           <= FUNC_CPU_RD;
        acc_if.address        <= '0;
        acc_if.write_data     <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.prg_bank_count <= BANK_COUNT_RST;
        rst_n                 <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, bank count still at its reset value
        issue('{FUNC_CPU_RD,  16'h5FFF, 8'h00});    // read below RAM: no target
        issue('{FUNC_INVALID, 16'hFFFF, 8'hFF});    // undefined kind: no effect
        issue('{FUNC_CPU_WR,  16'h0000, 8'h01});    // write below RAM: no effect
        issue('{FUNC_CPU_RD,  16'hC000, 8'h00});    // last bank fixed high
        issue('{FUNC_PPU,     16'hFFFF, 8'h00});    // PPU address beyond 0x1FFF
        serial_load(SEL_CTRL, 5'h00, 1'b0);         // 8KB CHR, 32KB PRG
        // two bits in, then the clearing write: control must stay as it is
        issue('{FUNC_CPU_WR,  16'h8000, 8'h01});
        issue('{FUNC_CPU_WR,  16'hA000, 8'h00});
        issue('{FUNC_CPU_WR,  16'h8000, 8'hFF});
        serial_load(SEL_CHR_LO, 5'h1F, 1'b0);       // odd bank masked in 8KB mode
        serial_load(SEL_CHR_HI, 5'h1F, 1'b0);       // dropped in 8KB mode
        serial_load(SEL_PRG,    5'h1F, 1'b0);       // odd bank masked, RAM off

        // bank count extremes, the wrap of zero and counts beyond sixteen
        counts[0] = 5'd1;
        counts[1] = 5'd31;
        counts[2] = 5'd0;
        counts[3] = 5'd16;
        counts[4] = 5'd17;
        counts[5] = COUNT_W'($urandom_range(1, 16));
        counts[6] = 5'd8;
        counts[7] = COUNT_W'($urandom_range(0, 31));

        for (int p = 0; p < 8; p++)
        begin
            // sender holds off until every result is back before each write
            drain_results();
            write_bank_count(counts[p]);
            tx_calm     = (p == 3);
            rx_calm     = (p == 3) || (p == 6);
            phase_count = 0;
            while (phase_count < PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 99) < 55)
                    serial_load(2'($urandom_range(0, 3)), 5'($urandom), 1'b1);
                else
                    issue(random_access());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/slbm_pkg.sv
hw/rtl/slbm_if.sv
hw/rtl/slbm_regs.sv
hw/rtl/slbm_xlate.sv
hw/rtl/serial_loaded_bank_mapper.sv
verif/tb.sv
